// ----- design/coo_pkg.sv -----
// Package for the COO to CSR converter: sizes, codes, state encoding and
// the weight normalizing function. No dependencies.
package coo_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_ENTRIES  = 8192;
  localparam int WEIGHT_BITS  = 32;

  localparam int VTX_W  = $clog2(MAX_VERTICES);       // vertex id
  localparam int VC_W   = $clog2(MAX_VERTICES + 1);   // vertex count, offset address
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);    // edge / entry count
  localparam int EA_W   = $clog2(MAX_ENTRIES);        // entry address
  localparam int VAL_W  = 14;                         // read_value field
  localparam int WT_W   = 32;                         // weight fields
  localparam int ES_W   = 2 * VTX_W + WT_W;           // edge store word
  localparam int ADJ_W  = VTX_W + WT_W;               // adjacency word

  typedef enum logic [2:0] {
    MODE_LOAD    = 3'd0,
    MODE_BUILD   = 3'd1,
    MODE_OUT_OFF = 3'd2,
    MODE_OUT_ENT = 3'd3,
    MODE_IN_OFF  = 3'd4,
    MODE_IN_ENT  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_BUILT     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_DIRECTED     = 1'd0,
    REG_VERTEX_COUNT = 1'd1
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_CLR,
    S_CNT_RD,
    S_CNT_CHK,
    S_CNT_WR1,
    S_CNT_RD2,
    S_CNT_WR2,
    S_PRE_RD,
    S_PRE_WR,
    S_PRE_END,
    S_SC_RD,
    S_SC_E,
    S_SC_W1,
    S_SC_R2,
    S_SC_W2
  } state_t;

  // keep the low WEIGHT_BITS bits, sign extended to the field width
  function automatic logic [WT_W-1:0] norm_weight(input logic [WT_W-1:0] w);
    logic [WT_W-1:0] r;
    for (int b = 0; b < WT_W; b++) begin
      r[b] = (b < WEIGHT_BITS) ? w[b] : w[WEIGHT_BITS-1];
    end
    return r;
  endfunction

endpackage

// ----- design/coo_if.sv -----
// Request and result channel interfaces (valid/ready) of the converter.
// Depends on coo_pkg.
interface coo_req_if import coo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [VTX_W-1:0]   src_vertex;
  logic [VTX_W-1:0]   dst_vertex;
  logic signed [31:0] edge_weight;
  logic [VAL_W-1:0]   read_index;

  modport source (output valid, mode, src_vertex, dst_vertex, edge_weight, read_index,
                  input ready);
  modport sink   (input valid, mode, src_vertex, dst_vertex, edge_weight, read_index,
                  output ready);
endinterface

interface coo_rsp_if import coo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   read_value;
  logic signed [31:0] read_weight;
  logic [1:0]         status;

  modport source (output valid, read_value, read_weight, status, input ready);
  modport sink   (input valid, read_value, read_weight, status, output ready);
endinterface

// ----- design/coo_ram.sv -----
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
module coo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/coo_to_csr_converter.sv -----
// Top level of the COO to CSR converter: sequencer, memories, output register.
// Depends on coo_pkg, coo_if (coo_req_if, coo_rsp_if) and coo_ram.
//
//  channel   | dir | protocol        | carries
//  ----------+-----+-----------------+---------------------------------------------
//  request   | in  | valid/ready     | mode, src_vertex, dst_vertex, edge_weight,
//            |     |                 | read_index
//  result    | out | valid/ready     | read_value, read_weight, status
//  cfg       | in  | we/index/data   | directed (index 0), vertex_count (index 1)
//
// Load and refused items go straight to the result register; reads via S_RD_WAIT.
// Build: clear n vertices, count edges, prefix sum over n with an end step, then
// scatter edges, with n the effective vertex count; the single read and single
// write port of the degree/cursor memories allow one update at a time.
// One request at a time: ready is low while a request is in work or its
// result waits in the output register. Reset is synchronous; no clearing pass,
// the degree memories are swept at the start of each build.
module coo_to_csr_converter import coo_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [VC_W-1:0] cfg_data,
  coo_req_if.sink         request,
  coo_rsp_if.source       result
);

  // ---------------------------------------------------------------- registers
  state_t            state, state_next;
  logic              directed;
  logic [VC_W-1:0]   vcount;
  logic [CNT_W-1:0]  edge_count, edge_count_next;
  logic              built, built_next;
  logic [CNT_W-1:0]  total, total_next;       // out_offset[n] of last build
  logic [CNT_W-1:0]  idx, idx_next;           // edge walk index
  logic [VC_W-1:0]   vtx, vtx_next;           // vertex walk index
  logic [CNT_W-1:0]  acc_o, acc_o_next;
  logic [CNT_W-1:0]  acc_i, acc_i_next;
  logic [VTX_W-1:0]  e_src, e_src_next;
  logic [VTX_W-1:0]  e_dst, e_dst_next;
  logic [WT_W-1:0]   e_wt, e_wt_next;
  logic              rd_entry, rd_entry_next; // pending read: entry (1) / offset (0)
  logic              rd_in, rd_in_next;       // pending read from in-arrays
  logic              ov, ov_next;
  logic [VAL_W-1:0]  o_val, o_val_next;
  logic [WT_W-1:0]   o_wt, o_wt_next;
  logic [1:0]        o_st, o_st_next;

  // effective vertex count: 0 reads as 1, saturates at MAX_VERTICES
  logic [VC_W-1:0] n_eff;
  assign n_eff = (vcount == '0) ? VC_W'(1) :
                 (vcount > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vcount;

  // ---------------------------------------------------------------- memories
  logic             es_we;
  logic [EA_W-1:0]  es_waddr, es_raddr;
  logic [ES_W-1:0]  es_wdata, es_q;

  logic             od_we, id_we;
  logic [VTX_W-1:0] od_waddr, od_raddr, id_waddr, id_raddr;
  logic [CNT_W-1:0] od_wdata, od_q, id_wdata, id_q;

  logic             oo_we, io_we;
  logic [VC_W-1:0]  oo_waddr, io_waddr, off_raddr;
  logic [CNT_W-1:0] oo_wdata, io_wdata, oo_q, io_q;

  logic             oa_we, ia_we;
  logic [EA_W-1:0]  oa_waddr, ia_waddr, adj_raddr;
  logic [ADJ_W-1:0] oa_wdata, ia_wdata, oa_q, ia_q;

  coo_ram #(.WIDTH(ES_W), .DEPTH(MAX_ENTRIES)) u_edge_store (
    .clk, .we(es_we), .waddr(es_waddr), .wdata(es_wdata), .raddr(es_raddr), .rdata(es_q));
  // degree counts, later reused as fill cursors
  coo_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_out_deg (
    .clk, .we(od_we), .waddr(od_waddr), .wdata(od_wdata), .raddr(od_raddr), .rdata(od_q));
  coo_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_in_deg (
    .clk, .we(id_we), .waddr(id_waddr), .wdata(id_wdata), .raddr(id_raddr), .rdata(id_q));
  coo_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES + 1)) u_out_off (
    .clk, .we(oo_we), .waddr(oo_waddr), .wdata(oo_wdata), .raddr(off_raddr), .rdata(oo_q));
  coo_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES + 1)) u_in_off (
    .clk, .we(io_we), .waddr(io_waddr), .wdata(io_wdata), .raddr(off_raddr), .rdata(io_q));
  coo_ram #(.WIDTH(ADJ_W), .DEPTH(MAX_ENTRIES)) u_out_adj (
    .clk, .we(oa_we), .waddr(oa_waddr), .wdata(oa_wdata), .raddr(adj_raddr), .rdata(oa_q));
  coo_ram #(.WIDTH(ADJ_W), .DEPTH(MAX_ENTRIES)) u_in_adj (
    .clk, .we(ia_we), .waddr(ia_waddr), .wdata(ia_wdata), .raddr(adj_raddr), .rdata(ia_q));

  // ---------------------------------------------------------------- handshake
  logic req_fire;
  assign request.ready = (state == S_IDLE) && !ov;
  assign req_fire      = request.valid && request.ready;

  assign result.valid       = ov;
  assign result.read_value  = o_val;
  assign result.read_weight = o_wt;
  assign result.status      = o_st;

  // fields of the edge store word
  logic [VTX_W-1:0] q_src, q_dst;
  assign q_src = es_q[ES_W-1 -: VTX_W];
  assign q_dst = es_q[WT_W +: VTX_W];

  logic [CNT_W:0] need;
  logic           use_in;
  assign need   = directed ? {1'b0, edge_count} : {edge_count, 1'b0};
  assign use_in = directed && (request.mode == MODE_IN_OFF || request.mode == MODE_IN_ENT);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_count <= '0;
      built      <= 1'b0;
      ov         <= 1'b0;
      directed   <= 1'b0;
      vcount     <= VC_W'(MAX_VERTICES);
    end else begin
      state      <= state_next;
      edge_count <= edge_count_next;
      // any register write invalidates the last build
      built      <= cfg_we ? 1'b0 : built_next;
      ov         <= ov_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_DIRECTED:     directed <= cfg_data[0];
          REG_VERTEX_COUNT: vcount   <= cfg_data;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    total    <= total_next;
    idx      <= idx_next;
    vtx      <= vtx_next;
    acc_o    <= acc_o_next;
    acc_i    <= acc_i_next;
    e_src    <= e_src_next;
    e_dst    <= e_dst_next;
    e_wt     <= e_wt_next;
    rd_entry <= rd_entry_next;
    rd_in    <= rd_in_next;
    o_val    <= o_val_next;
    o_wt     <= o_wt_next;
    o_st     <= o_st_next;
  end

  always_comb begin
    state_next      = state;
    edge_count_next = edge_count;
    built_next      = built;
    total_next      = total;
    idx_next        = idx;
    vtx_next        = vtx;
    acc_o_next      = acc_o;
    acc_i_next      = acc_i;
    e_src_next      = e_src;
    e_dst_next      = e_dst;
    e_wt_next       = e_wt;
    rd_entry_next   = rd_entry;
    rd_in_next      = rd_in;
    ov_next         = ov && !result.ready;
    o_val_next      = o_val;
    o_wt_next       = o_wt;
    o_st_next       = o_st;

    es_we = 1'b0; es_waddr = edge_count[EA_W-1:0];
    es_wdata = {request.src_vertex, request.dst_vertex, norm_weight(request.edge_weight)};
    es_raddr = idx[EA_W-1:0];
    od_we = 1'b0; od_waddr = vtx[VTX_W-1:0]; od_wdata = '0; od_raddr = vtx[VTX_W-1:0];
    id_we = 1'b0; id_waddr = vtx[VTX_W-1:0]; id_wdata = '0; id_raddr = vtx[VTX_W-1:0];
    oo_we = 1'b0; oo_waddr = vtx; oo_wdata = acc_o;
    io_we = 1'b0; io_waddr = vtx; io_wdata = acc_i;
    off_raddr = request.read_index[VC_W-1:0];
    oa_we = 1'b0; oa_waddr = od_q[EA_W-1:0]; oa_wdata = {e_dst, e_wt};
    ia_we = 1'b0; ia_waddr = id_q[EA_W-1:0]; ia_wdata = {e_src, e_wt};
    adj_raddr = request.read_index[EA_W-1:0];

    case (state)
      S_IDLE: begin
        if (req_fire) begin
          ov_next    = 1'b1;
          o_val_next = '0;
          o_wt_next  = '0;
          o_st_next  = ST_OVERFLOW;
          case (request.mode)
            MODE_LOAD: begin
              if (edge_count != CNT_W'(MAX_ENTRIES) &&
                  VC_W'(request.src_vertex) < n_eff &&
                  VC_W'(request.dst_vertex) < n_eff) begin
                es_we           = 1'b1;
                edge_count_next = edge_count + 1'b1;
                built_next      = 1'b0;
                o_val_next      = VAL_W'(edge_count + 1'b1);
                o_st_next       = ST_OK;
              end
            end
            MODE_BUILD: begin
              if (need <= (CNT_W+1)'(MAX_ENTRIES)) begin
                ov_next    = 1'b0;
                vtx_next   = '0;
                state_next = S_CLR;
              end
            end
            MODE_OUT_OFF, MODE_IN_OFF: begin
              if (!built) begin
                o_st_next = ST_NOT_BUILT;
              end else if (request.read_index <= VAL_W'(n_eff)) begin
                ov_next       = 1'b0;
                rd_entry_next = 1'b0;
                rd_in_next    = use_in;
                state_next    = S_RD_WAIT;
              end
            end
            MODE_OUT_ENT, MODE_IN_ENT: begin
              if (!built) begin
                o_st_next = ST_NOT_BUILT;
              end else if (request.read_index < VAL_W'(total)) begin
                ov_next       = 1'b0;
                rd_entry_next = 1'b1;
                rd_in_next    = use_in;
                state_next    = S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end

      S_RD_WAIT: begin
        ov_next    = 1'b1;
        o_st_next  = ST_OK;
        state_next = S_IDLE;
        if (rd_entry) begin
          o_val_next = VAL_W'(rd_in ? ia_q[WT_W +: VTX_W] : oa_q[WT_W +: VTX_W]);
          o_wt_next  = rd_in ? ia_q[WT_W-1:0] : oa_q[WT_W-1:0];
        end else begin
          o_val_next = VAL_W'(rd_in ? io_q : oo_q);
        end
      end

      // zero the degree counters of vertices below n
      S_CLR: begin
        od_we = 1'b1;
        id_we = 1'b1;
        vtx_next = vtx + 1'b1;
        if (vtx == n_eff - 1'b1) begin
          idx_next   = '0;
          state_next = S_CNT_RD;
        end
      end

      S_CNT_RD: begin
        if (idx == edge_count) begin
          vtx_next   = '0;
          acc_o_next = '0;
          acc_i_next = '0;
          state_next = S_PRE_RD;
        end else begin
          state_next = S_CNT_CHK;
        end
      end

      S_CNT_CHK: begin
        e_src_next = q_src;
        e_dst_next = q_dst;
        od_raddr   = q_src;
        id_raddr   = q_dst;
        if (VC_W'(q_src) >= n_eff || VC_W'(q_dst) >= n_eff) begin
          // endpoint out of range: refuse, offsets untouched
          ov_next    = 1'b1;
          o_val_next = '0;
          o_wt_next  = '0;
          o_st_next  = ST_OVERFLOW;
          state_next = S_IDLE;
        end else begin
          state_next = S_CNT_WR1;
        end
      end

      S_CNT_WR1: begin
        od_we    = 1'b1;
        od_waddr = e_src;
        od_wdata = od_q + 1'b1;
        if (directed) begin
          id_we      = 1'b1;
          id_waddr   = e_dst;
          id_wdata   = id_q + 1'b1;
          idx_next   = idx + 1'b1;
          state_next = S_CNT_RD;
        end else begin
          state_next = S_CNT_RD2;
        end
      end

      S_CNT_RD2: begin
        od_raddr   = e_dst;
        state_next = S_CNT_WR2;
      end

      S_CNT_WR2: begin
        od_we      = 1'b1;
        od_waddr   = e_dst;
        od_wdata   = od_q + 1'b1;
        idx_next   = idx + 1'b1;
        state_next = S_CNT_RD;
      end

      S_PRE_RD: begin
        state_next = S_PRE_WR;
      end

      // offset[v] = running sum; the counter becomes the fill cursor
      S_PRE_WR: begin
        oo_we = 1'b1;
        io_we = 1'b1;
        od_we = 1'b1;
        od_wdata = acc_o;
        id_we = 1'b1;
        id_wdata = acc_i;
        acc_o_next = acc_o + od_q;
        acc_i_next = acc_i + id_q;
        vtx_next = vtx + 1'b1;
        state_next = (vtx == n_eff - 1'b1) ? S_PRE_END : S_PRE_RD;
      end

      S_PRE_END: begin
        oo_we      = 1'b1;
        io_we      = 1'b1;
        total_next = acc_o;
        idx_next   = '0;
        state_next = S_SC_RD;
      end

      S_SC_RD: begin
        if (idx == edge_count) begin
          built_next = 1'b1;
          ov_next    = 1'b1;
          o_val_next = VAL_W'(total);
          o_wt_next  = '0;
          o_st_next  = ST_BUILT;
          state_next = S_IDLE;
        end else begin
          state_next = S_SC_E;
        end
      end

      S_SC_E: begin
        e_src_next = q_src;
        e_dst_next = q_dst;
        e_wt_next  = es_q[WT_W-1:0];
        od_raddr   = q_src;
        id_raddr   = q_dst;
        state_next = S_SC_W1;
      end

      S_SC_W1: begin
        oa_we    = 1'b1;
        od_we    = 1'b1;
        od_waddr = e_src;
        od_wdata = od_q + 1'b1;
        if (directed) begin
          ia_we      = 1'b1;
          id_we      = 1'b1;
          id_waddr   = e_dst;
          id_wdata   = id_q + 1'b1;
          idx_next   = idx + 1'b1;
          state_next = S_SC_RD;
        end else begin
          state_next = S_SC_R2;
        end
      end

      S_SC_R2: begin
        od_raddr   = e_dst;
        state_next = S_SC_W2;
      end

      // reverse edge of an undirected graph, same weight
      S_SC_W2: begin
        oa_we      = 1'b1;
        oa_wdata   = {e_src, e_wt};
        od_we      = 1'b1;
        od_waddr   = e_dst;
        od_wdata   = od_q + 1'b1;
        idx_next   = idx + 1'b1;
        state_next = S_SC_RD;
      end

      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  // a result only waits while the sequencer is idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    ov |-> state == S_IDLE) else $error("result pending outside idle");

  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
    edge_count <= CNT_W'(MAX_ENTRIES)) else $error("edge count beyond capacity");

  // scatter positions stay inside the entries counted by the prefix sum
  a_scatter_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_W1 || state == S_SC_W2) |-> od_q < total)
    else $error("scatter position beyond entry total");

  a_built_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(built) |-> $past(state) == S_SC_RD) else $error("built set outside build end");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !request.ready) else $error("ready while busy");
`endif

endmodule
